// File: sv/three_rotor_substitution_cipher_defines.svh
// Assertion macros shared by the rotor cipher RTL.
`ifndef THREE_ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH
`define THREE_ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rsc_pkg.sv
// Types and constants of the three-rotor substitution cipher.
`default_nettype none
package rsc_pkg;

    localparam int unsigned ALPHA     = 26;
    localparam int unsigned IDX_W     = 5;

    typedef logic [IDX_W-1:0] t_letter;

    localparam t_letter     ALPHA_MAX = t_letter'(ALPHA - 1);
    localparam t_letter     ALPHA_N   = t_letter'(ALPHA);

    localparam logic [7:0]  CH_LA     = 8'h61;  // 'a'
    localparam logic [7:0]  CH_LZ     = 8'h7a;  // 'z'
    localparam logic [7:0]  CH_UA     = 8'h41;  // 'A'
    localparam logic [7:0]  CH_UZ     = 8'h5a;  // 'Z'

    localparam logic        REQ_LOAD  = 1'b0;
    localparam logic        REQ_CHAR  = 1'b1;

    localparam logic [1:0]  ROTOR_1   = 2'd0;
    localparam logic [1:0]  ROTOR_2   = 2'd1;
    localparam logic [1:0]  ROTOR_3   = 2'd2;

    typedef struct packed {
        t_letter p1;
        t_letter p2;
        t_letter p3;
    } t_rotor_pos;

endpackage
`default_nettype wire

// File: sv/rsc_rotor.sv
// One rotor: 26-entry substitution table with position-offset lookup.
`default_nettype none
module rsc_rotor (
    input  wire logic            i_clk,
    input  wire logic            i_wr_en,
    input  wire rsc_pkg::t_letter i_wr_idx,
    input  wire rsc_pkg::t_letter i_wr_val,
    input  wire rsc_pkg::t_letter i_pos,
    input  wire rsc_pkg::t_letter i_idx,
    output rsc_pkg::t_letter      o_val
);

    rsc_pkg::t_letter r_tab [rsc_pkg::ALPHA];

    logic [rsc_pkg::IDX_W:0] w_sum;
    rsc_pkg::t_letter        w_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tab[i_wr_idx] <= i_wr_val;
        end
    end

    always_comb begin
        w_sum = {1'b0, i_idx} + {1'b0, i_pos};
        if (w_sum >= {1'b0, rsc_pkg::ALPHA_N}) begin
            w_addr = rsc_pkg::t_letter'(w_sum - {1'b0, rsc_pkg::ALPHA_N});
        end else begin
            w_addr = w_sum[rsc_pkg::IDX_W-1:0];
        end
    end

    assign o_val = r_tab[w_addr];

endmodule
`default_nettype wire

// File: sv/rsc_stepper.sv
// Odometer stepping of the three rotor positions.
`default_nettype none
module rsc_stepper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_advance,
    output rsc_pkg::t_rotor_pos o_pos
);

    rsc_pkg::t_rotor_pos r_pos;
    rsc_pkg::t_rotor_pos n_pos;

    always_comb begin
        n_pos = r_pos;
        if (i_advance) begin
            if (r_pos.p1 == rsc_pkg::ALPHA_MAX) begin
                n_pos.p1 = '0;
                if (r_pos.p2 == rsc_pkg::ALPHA_MAX) begin
                    n_pos.p2 = '0;
                    if (r_pos.p3 == rsc_pkg::ALPHA_MAX) begin
                        n_pos.p3 = '0;
                    end else begin
                        n_pos.p3 = r_pos.p3 + 1'b1;
                    end
                end else begin
                    n_pos.p2 = r_pos.p2 + 1'b1;
                end
            end else begin
                n_pos.p1 = r_pos.p1 + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos = r_pos;

endmodule
`default_nettype wire

// File: sv/three_rotor_substitution_cipher.sv
// Three-rotor substitution cipher with odometer stepping, top level.
//
// Takes one beat per clock while the output is not stalled by i_m_tready
// and then gives back-to-back results. Every beat goes through an input
// register and, for a character, a result register; the three table lookups
// and their mod-26 adds sit in the single path between those registers.
// Load beats (tuser = 0) write at most one table entry and give no output beat; a
// character that follows a load in the next cycle already sees the new
// entry. Letters keep their case and step the rotors like an odometer;
// other bytes pass through and leave the positions alone. Tables sit in
// flip-flops with no clearing pass: a lookup of an entry never loaded
// since reset returns an undefined letter.
`default_nettype none
module three_rotor_substitution_cipher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [1:0] rotor_select, [6:2] entry_index, [11:7] entry_value,
    // [19:12] char_in, [23:20] zero
    input  wire logic [23:0] i_s_tdata,
    // [0] req_type
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [7:0] char_out
    output logic [7:0]       o_m_tdata
);

`include "three_rotor_substitution_cipher_defines.svh"

    logic             r_s1_valid;
    logic             r_s1_req;
    logic [1:0]       r_s1_sel;
    rsc_pkg::t_letter r_s1_idx;
    rsc_pkg::t_letter r_s1_val;
    logic [7:0]       r_s1_char;

    logic             r_out_valid;
    logic [7:0]       r_out_data;

    logic             w_out_free;
    logic             w_s1_fire;
    logic             w_s1_char;
    logic             w_s1_load;
    logic             w_letter;
    logic [7:0]       w_base;
    rsc_pkg::t_letter w_x;
    rsc_pkg::t_letter w_y1;
    rsc_pkg::t_letter w_y2;
    rsc_pkg::t_letter w_y3;
    rsc_pkg::t_letter w_wval;
    logic             w_idx_ok;
    logic [2:0]       w_wr_en;
    logic             w_advance;
    logic [7:0]       n_out_data;

    rsc_pkg::t_rotor_pos w_pos;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s1_fire  = r_s1_valid && ((r_s1_req == rsc_pkg::REQ_LOAD) || w_out_free);
    assign w_s1_char  = w_s1_fire && (r_s1_req == rsc_pkg::REQ_CHAR);
    assign w_s1_load  = w_s1_fire && (r_s1_req == rsc_pkg::REQ_LOAD);
    assign o_s_tready = !r_s1_valid || w_s1_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_req  <= i_s_tuser;
            r_s1_sel  <= i_s_tdata[1:0];
            r_s1_idx  <= i_s_tdata[6:2];
            r_s1_val  <= i_s_tdata[11:7];
            r_s1_char <= i_s_tdata[19:12];
        end
    end

    // letter detect and case base
    always_comb begin
        w_letter = 1'b1;
        w_base   = rsc_pkg::CH_LA;
        if (r_s1_char inside {[rsc_pkg::CH_LA:rsc_pkg::CH_LZ]}) begin
            w_base = rsc_pkg::CH_LA;
        end else if (r_s1_char inside {[rsc_pkg::CH_UA:rsc_pkg::CH_UZ]}) begin
            w_base = rsc_pkg::CH_UA;
        end else begin
            w_letter = 1'b0;
        end
    end

    assign w_x = rsc_pkg::t_letter'(r_s1_char - w_base);

    // load path
    assign w_wval   = (r_s1_val > rsc_pkg::ALPHA_MAX) ? (r_s1_val - rsc_pkg::ALPHA_N)
                                                      : r_s1_val;
    assign w_idx_ok = (r_s1_idx <= rsc_pkg::ALPHA_MAX);
    assign w_wr_en[0] = w_s1_load && w_idx_ok && (r_s1_sel == rsc_pkg::ROTOR_1);
    assign w_wr_en[1] = w_s1_load && w_idx_ok && (r_s1_sel == rsc_pkg::ROTOR_2);
    assign w_wr_en[2] = w_s1_load && w_idx_ok && (r_s1_sel == rsc_pkg::ROTOR_3);

    rsc_rotor u_rotor1 (
        .i_clk   (i_clk),
        .i_wr_en (w_wr_en[0]),
        .i_wr_idx(r_s1_idx),
        .i_wr_val(w_wval),
        .i_pos   (w_pos.p1),
        .i_idx   (w_x),
        .o_val   (w_y1)
    );

    rsc_rotor u_rotor2 (
        .i_clk   (i_clk),
        .i_wr_en (w_wr_en[1]),
        .i_wr_idx(r_s1_idx),
        .i_wr_val(w_wval),
        .i_pos   (w_pos.p2),
        .i_idx   (w_y1),
        .o_val   (w_y2)
    );

    rsc_rotor u_rotor3 (
        .i_clk   (i_clk),
        .i_wr_en (w_wr_en[2]),
        .i_wr_idx(r_s1_idx),
        .i_wr_val(w_wval),
        .i_pos   (w_pos.p3),
        .i_idx   (w_y2),
        .o_val   (w_y3)
    );

    assign w_advance = w_s1_char && w_letter;

    rsc_stepper u_stepper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .o_pos    (w_pos)
    );

    assign n_out_data = w_letter ? (w_base + {3'b000, w_y3}) : r_s1_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_s1_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_char) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `RSC_ASSERT_NEXT(a_char_gives_beat, w_s1_char, r_out_valid,
        "character beat did not reach the result register")
    `RSC_ASSERT_NEXT(a_passthru, w_s1_char && !w_letter,
        r_out_data == $past(r_s1_char), "non-letter byte was altered")
    `RSC_ASSERT_NEXT(a_pos_hold, !w_advance, $stable(w_pos),
        "rotor position moved without a letter")
    `RSC_ASSERT_NOW(a_pos_range, 1'b1,
        (w_pos.p1 <= rsc_pkg::ALPHA_MAX) && (w_pos.p2 <= rsc_pkg::ALPHA_MAX) &&
        (w_pos.p3 <= rsc_pkg::ALPHA_MAX), "rotor position out of range")
    `RSC_ASSERT_NEXT(a_load_no_beat, w_s1_load && !r_out_valid, !r_out_valid,
        "load beat produced an output beat")

endmodule
`default_nettype wire
